/* hw/rtl/pas_pkg.sv */
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types and codes of the periodic alarm scheduler.
// ----------------------------------------------------------------------------
package pas_pkg;

    localparam int DEF_ALARM_SLOTS = 16;
    localparam int DEF_MAX_FIRES   = 16;
    localparam int RESULT_CAP      = 16;
    localparam int TIME_W          = 64;
    localparam int HND_W           = 32;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_SET_ONE  = 2'd1;
    localparam logic [1:0] CMD_SET_PER  = 2'd2;
    localparam logic [1:0] CMD_CANCEL   = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FIRED     = 2'd1;
    localparam logic [1:0] ST_NONE_DUE  = 2'd2;
    localparam logic [1:0] ST_REJECT    = 2'd3;

    // one slot record as kept in memory; period zero marks a one-shot
    typedef struct packed {
        logic [TIME_W-1:0] next_fire;
        logic [TIME_W-1:0] period;
        logic [HND_W-1:0]  handler;
    } alarm_rec_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [3:0]        fired_slot;
        logic [TIME_W-1:0] fire_time;
        logic [HND_W-1:0]  fired_handler;
        logic              was_armed;
        logic              last;
    } result_t;

endpackage

/* hw/rtl/pas_req_if.sv */
// ----------------------------------------------------------------------------
// pas_req_if
// Request channel of the alarm scheduler: valid/ready plus command payload.
// ----------------------------------------------------------------------------
interface pas_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [3:0]  slot;
    logic [63:0] now_time;
    logic [63:0] delay_or_start;
    logic [63:0] period_ticks;
    logic [31:0] handler_word;

    modport source (output valid, command, slot, now_time, delay_or_start,
                    period_ticks, handler_word, input ready);
    modport sink   (input valid, command, slot, now_time, delay_or_start,
                    period_ticks, handler_word, output ready);
endinterface

/* hw/rtl/pas_rsp_if.sv */
// ----------------------------------------------------------------------------
// pas_rsp_if
// Result channel of the alarm scheduler: valid/ready plus result payload.
// ----------------------------------------------------------------------------
interface pas_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  fired_slot;
    logic [63:0] fire_time;
    logic [31:0] fired_handler;
    logic        was_armed;
    logic        last;

    modport source (output valid, status, fired_slot, fire_time, fired_handler,
                    was_armed, last, input ready);
    modport sink   (input valid, status, fired_slot, fire_time, fired_handler,
                    was_armed, last, output ready);
endinterface

/* hw/rtl/pas_ram.sv */
// ----------------------------------------------------------------------------
// pas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/periodic_alarm_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_alarm_scheduler
// Bank of alarm slots: one-shot and periodic set, cancel, and a tick that
// fires due alarms earliest first.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per handshake (valid & ready): tick, set
//   one-shot, set periodic, or cancel, each with the current time.
//   rsp returns one or more results per request; last marks the final one.
//   Slot records (next fire, period, handler) live in one RAM with a
//   registered read; armed bits sit in flip-flops.
// Sequencing:
//   set one-shot, cancel, rejected set: answered from S_RESP.
//   set periodic: when already started, runs the bit-serial 64-bit
//   remainder unit (one quotient bit per cycle) in S_DIV, then S_DWR.
//   tick: each firing costs one full RAM sweep, and a tick fires at most
//   min(MAX_FIRES,16) alarms.
//   One request is worked on at a time; req.ready is high while idle.
// Reset: all slots disarmed at once; the RAM needs no clearing pass.
// Stall: a held result stays in the output register; scans and the
//   division go on, but S_RESP, S_EMIT and S_FLUSH wait until it is free.
// ----------------------------------------------------------------------------
module periodic_alarm_scheduler
    import pas_pkg::*;
#(
    parameter int ALARM_SLOTS = DEF_ALARM_SLOTS,
    parameter int MAX_FIRES   = DEF_MAX_FIRES
) (
    input  logic       clk,
    input  logic       rst_n,
    pas_req_if.sink    req,
    pas_rsp_if.source  rsp
);
    localparam int SLOT_W = $clog2(ALARM_SLOTS);
    localparam int LIMIT  = (MAX_FIRES < RESULT_CAP) ? MAX_FIRES : RESULT_CAP;
    localparam int FIRE_W = $clog2(LIMIT + 1);
    localparam int REC_W  = $bits(alarm_rec_t);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_DWR   = 3'd2;
    localparam logic [2:0] S_RESP  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [ALARM_SLOTS-1:0] armed_reg, armed_next;

    // request context
    logic [3:0]        slot_reg, slot_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] per_reg, per_next;
    logic [HND_W-1:0]  hnd_reg, hnd_next;
    logic [1:0]        rstat_reg, rstat_next;
    logic              was_reg, was_next;

    // remainder unit
    logic [TIME_W-1:0] dvd_reg, dvd_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [5:0]        dcnt_reg, dcnt_next;

    // scan
    logic [SLOT_W:0]   scan_reg, scan_next;
    logic              rdv_reg, rdv_next;
    logic [SLOT_W-1:0] rdidx_reg, rdidx_next;
    logic              bestv_reg, bestv_next;
    logic [SLOT_W-1:0] bidx_reg, bidx_next;
    alarm_rec_t        best_reg, best_next;
    logic [FIRE_W-1:0] fires_reg, fires_next;
    logic              pendv_reg, pendv_next;
    result_t           pend_reg, pend_next;

    // output register
    logic              ovalid_reg, ovalid_next;
    result_t           out_reg, out_next;

    // RAM port
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    alarm_rec_t        mem_wdata;
    alarm_rec_t        mem_rdata;
    logic [REC_W-1:0]  mem_rbits;

    logic              out_free;
    logic              in_range;
    logic [SLOT_W-1:0] req_idx;
    logic [TIME_W:0]   div_sh;
    logic [TIME_W:0]   div_diff;

    pas_ram #(
        .WIDTH (REC_W),
        .DEPTH (ALARM_SLOTS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (scan_reg[SLOT_W-1:0]),
        .rdata (mem_rbits)
    );

    assign mem_rdata = alarm_rec_t'(mem_rbits);
    assign out_free  = !ovalid_reg || rsp.ready;
    assign in_range  = 32'(req.slot) < ALARM_SLOTS;
    assign req_idx   = SLOT_W'(req.slot);
    assign req.ready = (state_reg == S_IDLE);

    assign div_sh   = {rem_reg, dvd_reg[TIME_W-1]};
    assign div_diff = div_sh - {1'b0, per_reg};

    assign rsp.valid         = ovalid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.fired_slot    = out_reg.fired_slot;
    assign rsp.fire_time     = out_reg.fire_time;
    assign rsp.fired_handler = out_reg.fired_handler;
    assign rsp.was_armed     = out_reg.was_armed;
    assign rsp.last          = out_reg.last;

    always_comb
    begin
        state_next  = state_reg;
        armed_next  = armed_reg;
        slot_next   = slot_reg;
        now_next    = now_reg;
        per_next    = per_reg;
        hnd_next    = hnd_reg;
        rstat_next  = rstat_reg;
        was_next    = was_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        scan_next   = scan_reg;
        rdv_next    = 1'b0;
        rdidx_next  = rdidx_reg;
        bestv_next  = bestv_reg;
        bidx_next   = bidx_reg;
        best_next   = best_reg;
        fires_next  = fires_reg;
        pendv_next  = pendv_reg;
        pend_next   = pend_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        out_next    = out_reg;
        mem_we      = 1'b0;
        mem_waddr   = req_idx;
        mem_wdata   = '{next_fire: req.now_time + req.delay_or_start,
                        period: '0, handler: req.handler_word};

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    slot_next  = req.slot;
                    now_next   = req.now_time;
                    per_next   = req.period_ticks;
                    hnd_next   = req.handler_word;
                    rstat_next = ST_DONE;
                    was_next   = 1'b0;
                    state_next = S_RESP;
                    case (req.command)
                        CMD_TICK:
                        begin
                            scan_next  = '0;
                            bestv_next = 1'b0;
                            fires_next = '0;
                            pendv_next = 1'b0;
                            state_next = S_SCAN;
                        end
                        CMD_SET_ONE:
                        begin
                            if (in_range)
                            begin
                                mem_we              = 1'b1;
                                armed_next[req_idx] = 1'b1;
                            end
                        end
                        CMD_SET_PER:
                        begin
                            if (req.period_ticks == '0)
                            begin
                                rstat_next = ST_REJECT;
                            end
                            else if (in_range)
                            begin
                                if (req.now_time < req.delay_or_start)
                                begin
                                    // not yet started: first fire is start
                                    mem_we              = 1'b1;
                                    mem_wdata.next_fire = req.delay_or_start;
                                    mem_wdata.period    = req.period_ticks;
                                    armed_next[req_idx] = 1'b1;
                                end
                                else
                                begin
                                    dvd_next   = req.now_time - req.delay_or_start;
                                    rem_next   = '0;
                                    dcnt_next  = '0;
                                    state_next = S_DIV;
                                end
                            end
                        end
                        default:
                        begin
                            if (in_range)
                            begin
                                was_next            = armed_reg[req_idx];
                                armed_next[req_idx] = 1'b0;
                            end
                        end
                    endcase
                end
            end

            S_DIV:
            begin
                // restoring step: one quotient bit, only the remainder is kept
                rem_next  = div_diff[TIME_W] ? div_sh[TIME_W-1:0]
                                             : div_diff[TIME_W-1:0];
                dvd_next  = {dvd_reg[TIME_W-2:0], 1'b0};
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd63)
                begin
                    state_next = S_DWR;
                end
            end

            S_DWR:
            begin
                // start + (q+1)*per == now - rem + per (mod 2^64)
                mem_we                          = 1'b1;
                mem_waddr                       = SLOT_W'(slot_reg);
                mem_wdata.next_fire             = now_reg - rem_reg + per_reg;
                mem_wdata.period                = per_reg;
                mem_wdata.handler               = hnd_reg;
                armed_next[SLOT_W'(slot_reg)]   = 1'b1;
                state_next                      = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    out_next    = '{status: rstat_reg, fired_slot: slot_reg,
                                    fire_time: '0, fired_handler: '0,
                                    was_armed: was_reg, last: 1'b1};
                    state_next  = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (scan_reg < (SLOT_W+1)'(ALARM_SLOTS))
                begin
                    rdv_next   = 1'b1;
                    rdidx_next = scan_reg[SLOT_W-1:0];
                    scan_next  = scan_reg + 1'b1;
                end
                if (rdv_reg)
                begin
                    if (armed_reg[rdidx_reg] && mem_rdata.next_fire <= now_reg &&
                        (!bestv_reg || mem_rdata.next_fire < best_reg.next_fire))
                    begin
                        bestv_next = 1'b1;
                        bidx_next  = rdidx_reg;
                        best_next  = mem_rdata;
                    end
                    if (rdidx_reg == SLOT_W'(ALARM_SLOTS - 1))
                    begin
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    if (bestv_reg)
                    begin
                        // previous firing is not the final one
                        if (pendv_reg)
                        begin
                            ovalid_next = 1'b1;
                            out_next    = pend_reg;
                        end
                        pendv_next = 1'b1;
                        pend_next  = '{status: ST_FIRED, fired_slot: 4'(bidx_reg),
                                       fire_time: best_reg.next_fire,
                                       fired_handler: best_reg.handler,
                                       was_armed: 1'b0, last: 1'b0};
                        if (best_reg.period == '0)
                        begin
                            armed_next[bidx_reg] = 1'b0;
                        end
                        else
                        begin
                            mem_we              = 1'b1;
                            mem_waddr           = bidx_reg;
                            mem_wdata           = best_reg;
                            mem_wdata.next_fire = best_reg.next_fire + best_reg.period;
                        end
                        fires_next = fires_reg + 1'b1;
                        if (fires_reg == FIRE_W'(LIMIT - 1))
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            scan_next  = '0;
                            bestv_next = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        ovalid_next = 1'b1;
                        if (pendv_reg)
                        begin
                            out_next      = pend_reg;
                            out_next.last = 1'b1;
                        end
                        else
                        begin
                            out_next = '{status: ST_NONE_DUE, fired_slot: '0,
                                         fire_time: '0, fired_handler: '0,
                                         was_armed: 1'b0, last: 1'b1};
                        end
                        state_next = S_IDLE;
                    end
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    ovalid_next   = 1'b1;
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            armed_reg  <= '0;
            ovalid_reg <= 1'b0;
            rdv_reg    <= 1'b0;
            bestv_reg  <= 1'b0;
            pendv_reg  <= 1'b0;
            fires_reg  <= '0;
            scan_reg   <= '0;
            dcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            armed_reg  <= armed_next;
            ovalid_reg <= ovalid_next;
            rdv_reg    <= rdv_next;
            bestv_reg  <= bestv_next;
            pendv_reg  <= pendv_next;
            fires_reg  <= fires_next;
            scan_reg   <= scan_next;
            dcnt_reg   <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        now_reg   <= now_next;
        per_reg   <= per_next;
        hnd_reg   <= hnd_next;
        rstat_reg <= rstat_next;
        was_reg   <= was_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        rdidx_reg <= rdidx_next;
        bidx_reg  <= bidx_next;
        best_reg  <= best_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end
endmodule
